// ===== sv/rkob_pkg.sv =====
package rkob_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLOBAL_ALPHA = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_ORDER    = 1'b1;

    localparam logic [7:0] GLOBAL_ALPHA_RESET = 8'd255;

    // Key order codes.
    localparam logic KEY_ORDER_RGBA = 1'b0;
    localparam logic KEY_ORDER_BGRA = 1'b1;

    // Alpha scaling rounding term.
    localparam logic [16:0] ALPHA_ROUND = 17'd511;

    // BT.601 studio-range conversion coefficients.
    localparam logic [15:0] LUMA_OFFSET   = 16'd4096;
    localparam logic [15:0] Y_R           = 16'd66;
    localparam logic [15:0] Y_G           = 16'd129;
    localparam logic [15:0] Y_B           = 16'd25;
    localparam logic [16:0] CHROMA_OFFSET = 17'd32768;
    localparam logic [16:0] CB_R          = 17'd38;
    localparam logic [16:0] CB_G          = 17'd74;
    localparam logic [16:0] CB_B          = 17'd112;
    localparam logic [16:0] CR_R          = 17'd112;
    localparam logic [16:0] CR_G          = 17'd94;
    localparam logic [16:0] CR_B          = 17'd18;

    // Blend rounding term.
    localparam logic [19:0] MIX_ROUND = 20'd256;

    typedef struct packed {
        logic [7:0] global_alpha;
        logic       key_order;
    } t_cfg;

    // One classified item as the front end hands it to the back end.
    typedef struct packed {
        logic [7:0] bg_cb;
        logic [7:0] bg_luma0;
        logic [7:0] bg_cr;
        logic [7:0] bg_luma1;
        logic [7:0] red0;
        logic [7:0] green0;
        logic [7:0] blue0;
        logic [7:0] red1;
        logic [7:0] green1;
        logic [7:0] blue1;
        logic [7:0] filt_red;
        logic [7:0] filt_green;
        logic [7:0] filt_blue;
        logic [8:0] alpha0;
        logic [8:0] alpha1;
        logic [8:0] alpha_chroma;
        logic       skip;
    } t_front_item;

endpackage

// ===== sv/rkob_ifs.sv =====
interface rkob_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  bg_cb;
    logic [7:0]  bg_luma0;
    logic [7:0]  bg_cr;
    logic [7:0]  bg_luma1;
    logic [31:0] key_first;
    logic [31:0] key_second;
    logic        line_start;

    modport source (
        output valid, bg_cb, bg_luma0, bg_cr, bg_luma1, key_first, key_second, line_start,
        input  ready
    );
    modport sink (
        input  valid, bg_cb, bg_luma0, bg_cr, bg_luma1, key_first, key_second, line_start,
        output ready
    );
endinterface

interface rkob_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_cb;
    logic [7:0] out_luma0;
    logic [7:0] out_cr;
    logic [7:0] out_luma1;

    modport source (
        output valid, out_cb, out_luma0, out_cr, out_luma1,
        input  ready
    );
    modport sink (
        input  valid, out_cb, out_luma0, out_cr, out_luma1,
        output ready
    );
endinterface

// ===== sv/rgba_key_over_ycbcr422_blend.sv =====
// Alpha keyer that lays two RGBA (or BGRA) key pixels over one 4:2:2 YCbCr
// background pair per item. The block takes one item per clock while its queue
// has room and returns one result item per input item, in order. The front
// end splits the key pixels, scales alpha and runs the [1 2 1] chroma filter in
// the accepting cycle, so the item is written into the queue at the accepting
// edge; the back end then pops it and registers the BT.601 conversion, and the
// blend lands in the output register after that. The queue between front and
// back end is QUEUE_DEPTH items deep, so the input keeps flowing while a result
// waits to be taken; with the output stalled the block holds up to QUEUE_DEPTH + 2
// items before it drops ready. The filter history (previous key pixel) is updated
// by every accepted item, so the line_start flag must mark the first pair of every
// scanline.
// Configuration registers: index 0 is the global opacity (reset 255), index 1
// selects the key byte order (0 RGBA, 1 BGRA with the transparent-pair bypass).
// Write them only while no item is in flight.
module rgba_key_over_ycbcr422_blend #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rkob_in_if.sink                             i_in,
    rkob_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [rkob_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [rkob_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    rkob_pkg::t_cfg        r_cfg, n_cfg;
    rkob_pkg::t_front_item push_item, pop_item;
    logic                  push, q_ready, q_valid, pop;

    // Register file: the write lands at the clock edge where the enable is high.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                rkob_pkg::CFG_GLOBAL_ALPHA: begin
                    n_cfg.global_alpha = i_cfg_wdata[7:0];
                end
                rkob_pkg::CFG_KEY_ORDER: begin
                    n_cfg.key_order = i_cfg_wdata[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.global_alpha <= rkob_pkg::GLOBAL_ALPHA_RESET;
            r_cfg.key_order    <= rkob_pkg::KEY_ORDER_RGBA;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front end: splits the key pixels, scales alpha and filters chroma.
    rkob_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (r_cfg),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_item    (push_item)
    );

    // Decoupling queue between the two halves.
    rkob_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (pop_item),
        .i_pop   (pop)
    );

    // Back end: color conversion and blend, with the registered output.
    rkob_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (pop_item),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // A pushed item is visible to the back end on the next cycle.
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> q_valid)
        else $error("queue empty after a push");

    // A full queue is never empty.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_ready |-> q_valid)
        else $error("queue reports full and empty at once");

    // The back end never pops from an empty queue.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("pop from an empty queue");

    // Reset leaves no result on the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

    // A global opacity write takes effect at the next cycle.
    a_cfg_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_index == rkob_pkg::CFG_GLOBAL_ALPHA))
        |=> (r_cfg.global_alpha == $past(i_cfg_wdata[7:0])))
        else $error("global opacity write lost");

endmodule

// ===== sv/rkob_front.sv =====
module rkob_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rkob_in_if.sink               i_in,
    input  rkob_pkg::t_cfg        i_cfg,
    input  logic                  i_q_ready,
    output logic                  o_push,
    output rkob_pkg::t_front_item o_item
);

    logic [7:0]  red0, green0, blue0, alpha0;
    logic [7:0]  red1, green1, blue1, alpha1;
    logic [16:0] scaled0, scaled1, global_x;
    logic [8:0]  k0, k1;
    logic [7:0]  prev_red, prev_green, prev_blue;
    logic [8:0]  prev_alpha;
    logic [9:0]  sum_red, sum_green, sum_blue;
    logic [10:0] sum_alpha;
    logic        accept;

    logic [7:0]  r_prev_red, r_prev_green, r_prev_blue;
    logic [8:0]  r_prev_alpha;

    // In BGRA order the low and high color bytes swap places.
    always_comb begin
        green0 = i_in.key_first[15:8];
        alpha0 = i_in.key_first[31:24];
        green1 = i_in.key_second[15:8];
        alpha1 = i_in.key_second[31:24];
        if (i_cfg.key_order == rkob_pkg::KEY_ORDER_BGRA) begin
            blue0 = i_in.key_first[7:0];
            red0  = i_in.key_first[23:16];
            blue1 = i_in.key_second[7:0];
            red1  = i_in.key_second[23:16];
        end else begin
            red0  = i_in.key_first[7:0];
            blue0 = i_in.key_first[23:16];
            red1  = i_in.key_second[7:0];
            blue1 = i_in.key_second[23:16];
        end
    end

    assign global_x = {9'd0, i_cfg.global_alpha};
    assign scaled0  = {9'd0, alpha0} * global_x + rkob_pkg::ALPHA_ROUND;
    assign scaled1  = {9'd0, alpha1} * global_x + rkob_pkg::ALPHA_ROUND;
    assign k0       = scaled0[16:8];
    assign k1       = scaled1[16:8];

    // At a line start the first pixel stands in for the previous one.
    always_comb begin
        if (i_in.line_start) begin
            prev_red   = red0;
            prev_green = green0;
            prev_blue  = blue0;
            prev_alpha = k0;
        end else begin
            prev_red   = r_prev_red;
            prev_green = r_prev_green;
            prev_blue  = r_prev_blue;
            prev_alpha = r_prev_alpha;
        end
    end

    assign sum_red   = {2'b0, prev_red}   + {1'b0, red0, 1'b0}   + {2'b0, red1};
    assign sum_green = {2'b0, prev_green} + {1'b0, green0, 1'b0} + {2'b0, green1};
    assign sum_blue  = {2'b0, prev_blue}  + {1'b0, blue0, 1'b0}  + {2'b0, blue1};
    assign sum_alpha = {2'b0, prev_alpha} + {1'b0, k0, 1'b0}     + {2'b0, k1};

    assign accept     = i_in.valid && i_q_ready;
    assign i_in.ready = i_q_ready;
    assign o_push     = accept;

    always_comb begin
        o_item.bg_cb        = i_in.bg_cb;
        o_item.bg_luma0     = i_in.bg_luma0;
        o_item.bg_cr        = i_in.bg_cr;
        o_item.bg_luma1     = i_in.bg_luma1;
        o_item.red0         = red0;
        o_item.green0       = green0;
        o_item.blue0        = blue0;
        o_item.red1         = red1;
        o_item.green1       = green1;
        o_item.blue1        = blue1;
        o_item.filt_red     = sum_red[9:2];
        o_item.filt_green   = sum_green[9:2];
        o_item.filt_blue    = sum_blue[9:2];
        o_item.alpha0       = k0;
        o_item.alpha1       = k1;
        o_item.alpha_chroma = sum_alpha[10:2];
        o_item.skip         = (i_cfg.key_order == rkob_pkg::KEY_ORDER_BGRA)
                              && (k0 == 9'd0) && (k1 == 9'd0);
    end

    // The second pixel becomes the previous pixel of the next item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_red   <= '0;
            r_prev_green <= '0;
            r_prev_blue  <= '0;
            r_prev_alpha <= '0;
        end else if (accept) begin
            r_prev_red   <= red1;
            r_prev_green <= green1;
            r_prev_blue  <= blue1;
            r_prev_alpha <= k1;
        end
    end

endmodule

// ===== sv/rkob_queue.sv =====
module rkob_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  rkob_pkg::t_front_item i_item,
    output logic                  o_ready,
    output logic                  o_valid,
    output rkob_pkg::t_front_item o_item,
    input  logic                  i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    rkob_pkg::t_front_item r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== sv/rkob_back.sv =====
module rkob_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rkob_pkg::t_front_item i_item,
    output logic                  o_pop,
    rkob_out_if.source            o_out
);

    typedef struct packed {
        logic [7:0] bg_cb;
        logic [7:0] bg_luma0;
        logic [7:0] bg_cr;
        logic [7:0] bg_luma1;
        logic [7:0] fg_cb;
        logic [7:0] fg_luma0;
        logic [7:0] fg_cr;
        logic [7:0] fg_luma1;
        logic [8:0] alpha0;
        logic [8:0] alpha1;
        logic [8:0] alpha_chroma;
        logic       skip;
    } t_back_item;

    function automatic logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [15:0] acc;
        acc = rkob_pkg::LUMA_OFFSET + rkob_pkg::Y_R * {8'd0, r}
              + rkob_pkg::Y_G * {8'd0, g} + rkob_pkg::Y_B * {8'd0, b};
        return acc[15:8];
    endfunction

    // bg*(255-k) + fg*k + 256 rewritten as 255*bg + (fg-bg)*k + 256. The sum
    // never goes negative and never exceeds 16 bits for these inputs.
    function automatic logic [7:0] mix(logic [7:0] bg, logic [7:0] fg, logic [8:0] k);
        logic signed [9:0]  diff;
        logic signed [19:0] prod;
        logic signed [19:0] acc;
        diff = $signed({2'b0, fg}) - $signed({2'b0, bg});
        prod = diff * $signed({1'b0, k});
        acc  = $signed({4'b0, bg, 8'b0}) - $signed({12'b0, bg}) + prod
               + $signed(rkob_pkg::MIX_ROUND);
        return acc[15:8];
    endfunction

    t_back_item  n_s1, r_s1;
    logic        r_s1_valid, r_o_valid;
    logic [16:0] cb_acc, cr_acc;
    logic        out_free, s1_move, s1_free;
    logic [7:0]  r_out_cb, r_out_luma0, r_out_cr, r_out_luma1;

    assign out_free = !r_o_valid || o_out.ready;
    assign s1_move  = r_s1_valid && out_free;
    assign s1_free  = !r_s1_valid || s1_move;
    assign o_pop    = i_valid && s1_free;

    assign cb_acc = rkob_pkg::CHROMA_OFFSET + rkob_pkg::CB_B * {9'd0, i_item.filt_blue}
                    - rkob_pkg::CB_R * {9'd0, i_item.filt_red}
                    - rkob_pkg::CB_G * {9'd0, i_item.filt_green};
    assign cr_acc = rkob_pkg::CHROMA_OFFSET + rkob_pkg::CR_R * {9'd0, i_item.filt_red}
                    - rkob_pkg::CR_G * {9'd0, i_item.filt_green}
                    - rkob_pkg::CR_B * {9'd0, i_item.filt_blue};

    always_comb begin
        n_s1.bg_cb        = i_item.bg_cb;
        n_s1.bg_luma0     = i_item.bg_luma0;
        n_s1.bg_cr        = i_item.bg_cr;
        n_s1.bg_luma1     = i_item.bg_luma1;
        n_s1.fg_cb        = cb_acc[15:8];
        n_s1.fg_luma0     = luma_of(i_item.red0, i_item.green0, i_item.blue0);
        n_s1.fg_cr        = cr_acc[15:8];
        n_s1.fg_luma1     = luma_of(i_item.red1, i_item.green1, i_item.blue1);
        n_s1.alpha0       = i_item.alpha0;
        n_s1.alpha1       = i_item.alpha1;
        n_s1.alpha_chroma = i_item.alpha_chroma;
        n_s1.skip         = i_item.skip;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= n_s1;
        end
        if (s1_move) begin
            if (r_s1.skip) begin
                r_out_cb    <= r_s1.bg_cb;
                r_out_luma0 <= r_s1.bg_luma0;
                r_out_cr    <= r_s1.bg_cr;
                r_out_luma1 <= r_s1.bg_luma1;
            end else begin
                r_out_cb    <= mix(r_s1.bg_cb, r_s1.fg_cb, r_s1.alpha_chroma);
                r_out_luma0 <= mix(r_s1.bg_luma0, r_s1.fg_luma0, r_s1.alpha0);
                r_out_cr    <= mix(r_s1.bg_cr, r_s1.fg_cr, r_s1.alpha_chroma);
                r_out_luma1 <= mix(r_s1.bg_luma1, r_s1.fg_luma1, r_s1.alpha1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_pop;
            end
            if (out_free) begin
                r_o_valid <= s1_move;
            end
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.out_cb    = r_out_cb;
    assign o_out.out_luma0 = r_out_luma0;
    assign o_out.out_cr    = r_out_cr;
    assign o_out.out_luma1 = r_out_luma1;

endmodule

// ===== bench/rgba_key_over_ycbcr422_blend_tb.sv =====
module rgba_key_over_ycbcr422_blend_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Percentages of cycles in which a side holds back.
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 87;
    localparam int IDLE_LIGHT = 15;

    // Cycles allowed after the last result before the block counts as quiet.
    // The pipeline is three stages deep, so this leaves ample margin.
    localparam int SETTLE_CYCLES = 10;

    // One background pair with its two key pixels, as the input channel carries it.
    typedef struct packed {
        logic [7:0]  cb;
        logic [7:0]  y0;
        logic [7:0]  cr;
        logic [7:0]  y1;
        logic [31:0] key0;
        logic [31:0] key1;
        logic        line_start;
    } t_pair;

    // One composited pair, as the output channel carries it.
    typedef struct packed {
        logic [7:0] cb;
        logic [7:0] y0;
        logic [7:0] cr;
        logic [7:0] y1;
    } t_blend;

    // Clock, reset and every block input start at known values at time zero.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                             cfg_we = 1'b0;
    logic [rkob_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [rkob_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic  drv_valid = 1'b0;
    t_pair drv_pair = '0;
    logic  drv_ready = 1'b0;

    // Set at each rising edge when the input channel moved an item.
    logic in_taken = 1'b0;

    rkob_in_if  in_if ();
    rkob_out_if out_if ();

    assign in_if.valid      = drv_valid;
    assign in_if.bg_cb      = drv_pair.cb;
    assign in_if.bg_luma0   = drv_pair.y0;
    assign in_if.bg_cr      = drv_pair.cr;
    assign in_if.bg_luma1   = drv_pair.y1;
    assign in_if.key_first  = drv_pair.key0;
    assign in_if.key_second = drv_pair.key1;
    assign in_if.line_start = drv_pair.line_start;
    assign out_if.ready     = drv_ready;

    rgba_key_over_ycbcr422_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // Period of 20 ns.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Items waiting to be offered, and result items still owed by the block.
    t_pair  pairs_pending[$];
    t_blend blends_due[$];

    int send_idle_pct = IDLE_NONE;
    int recv_stall_pct = IDLE_NONE;

    int queued_n = 0;
    int accepted_n = 0;
    int checked_n = 0;
    int settings_n = 1;
    int errors = 0;

    // Row position for the random part: items left in the current scanline.
    int line_left = 0;

    // Our own copy of the register file and of the filter history.
    logic [7:0] opacity = rkob_pkg::GLOBAL_ALPHA_RESET;
    logic       key_order = rkob_pkg::KEY_ORDER_RGBA;
    int         hist_red = 0;
    int         hist_green = 0;
    int         hist_blue = 0;
    int         hist_alpha = 0;

    // Key alpha times the global opacity, rounded up so that it lands in 1..256.
    function automatic int scaled_alpha(input logic [7:0] a);
        int prod;
        prod = int'(a) * int'(opacity) + 511;
        return prod >>> 8;
    endfunction

    // Weighted blend of background and key sample. A weight of 256 makes the
    // background term negative; the clamps keep the sum in byte range anyway.
    function automatic logic [7:0] mix_sample(input logic [7:0] bg, input int fg, input int k);
        int n;
        n = int'(bg) * (255 - k) + fg * k + 256;
        if (n < 0) begin
            n = 0;
        end
        n = n >>> 8;
        if (n > 255) begin
            n = 255;
        end
        return n[7:0];
    endfunction

    // Computes the result item for one accepted input item and advances the
    // filter history, exactly as the block does for every item it takes.
    function automatic t_blend key_over_pair(input t_pair p);
        int r0, g0, b0, r1, g1, b1, k0, k1;
        int pr, pg, pb, pk, fr, fg, fb, kc;
        int luma0, luma1, chroma_b, chroma_r;
        t_blend res;
        // The byte order swaps only red and blue; green and alpha never move.
        if (key_order == rkob_pkg::KEY_ORDER_BGRA) begin
            r0 = p.key0[23:16];
            b0 = p.key0[7:0];
            r1 = p.key1[23:16];
            b1 = p.key1[7:0];
        end else begin
            r0 = p.key0[7:0];
            b0 = p.key0[23:16];
            r1 = p.key1[7:0];
            b1 = p.key1[23:16];
        end
        g0 = p.key0[15:8];
        g1 = p.key1[15:8];
        k0 = scaled_alpha(p.key0[31:24]);
        k1 = scaled_alpha(p.key1[31:24]);

        // At a line start the left neighbor is the first pixel itself.
        if (p.line_start) begin
            pr = r0;
            pg = g0;
            pb = b0;
            pk = k0;
        end else begin
            pr = hist_red;
            pg = hist_green;
            pb = hist_blue;
            pk = hist_alpha;
        end
        fr = (pr + 2 * r0 + r1) >>> 2;
        fg = (pg + 2 * g0 + g1) >>> 2;
        fb = (pb + 2 * b0 + b1) >>> 2;
        kc = (pk + 2 * k0 + k1) >>> 2;

        // History follows the second pixel of every item, skipped or not.
        hist_red = r1;
        hist_green = g1;
        hist_blue = b1;
        hist_alpha = k1 & 'h1ff;

        if (key_order == rkob_pkg::KEY_ORDER_BGRA && k0 == 0 && k1 == 0) begin
            res.cb = p.cb;
            res.y0 = p.y0;
            res.cr = p.cr;
            res.y1 = p.y1;
        end else begin
            luma0 = (4096 + 66 * r0 + 129 * g0 + 25 * b0) >>> 8;
            luma1 = (4096 + 66 * r1 + 129 * g1 + 25 * b1) >>> 8;
            chroma_b = (32768 - 38 * fr - 74 * fg + 112 * fb) >>> 8;
            chroma_r = (32768 + 112 * fr - 94 * fg - 18 * fb) >>> 8;
            res.cb = mix_sample(p.cb, chroma_b, kc);
            res.y0 = mix_sample(p.y0, luma0, k0);
            res.cr = mix_sample(p.cr, chroma_r, kc);
            res.y1 = mix_sample(p.y1, luma1, k1);
        end
        return res;
    endfunction

    // Input driver: changes only at the falling edge. An item that is offered
    // stays on the bus until the block has taken it.
    always @(negedge i_clk) begin : drive_pairs
        logic offer;
        offer = 1'b0;
        if (i_rst_n && !(drv_valid && !in_taken)) begin
            if (pairs_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_pair <= pairs_pending.pop_front();
                offer = 1'b1;
            end
            drv_valid <= offer;
        end
    end

    // Output back-pressure, also changed at the falling edge.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            drv_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every item the block accepts is predicted at once. Registers never change
    // while items are in flight, so the prediction uses the current settings.
    always @(posedge i_clk) begin
        in_taken <= in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            blends_due.push_back(key_over_pair(drv_pair));
            accepted_n <= accepted_n + 1;
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Result checker: each accepted result item is matched against the oldest
    // prediction still waiting.
    always @(posedge i_clk) begin : check_blends
        t_blend want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            checked_n++;
            if (blends_due.size() == 0) begin
                $error("result item with no prediction waiting: cb %0d y0 %0d cr %0d y1 %0d",
                       out_if.out_cb, out_if.out_luma0, out_if.out_cr, out_if.out_luma1);
                errors++;
            end else begin
                want = blends_due.pop_front();
                check_field("out_cb", want.cb, out_if.out_cb);
                check_field("out_luma0", want.y0, out_if.out_luma0);
                check_field("out_cr", want.cr, out_if.out_cr);
                check_field("out_luma1", want.y1, out_if.out_luma1);
            end
        end
    end

    function automatic void add_pair(input logic [7:0] cb, input logic [7:0] y0,
                                     input logic [7:0] cr, input logic [7:0] y1,
                                     input logic [31:0] key0, input logic [31:0] key1,
                                     input logic line_start);
        t_pair p;
        p.cb = cb;
        p.y0 = y0;
        p.cr = cr;
        p.y1 = y1;
        p.key0 = key0;
        p.key1 = key1;
        p.line_start = line_start;
        pairs_pending.push_back(p);
        queued_n++;
    endfunction

    // Alpha is drawn with extra weight on fully transparent, fully opaque, nearly
    // transparent and nearly opaque keys, where scaling and blend have their edges.
    function automatic logic [7:0] random_alpha();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'($urandom_range(1, 3));
            3: return 8'($urandom_range(252, 254));
            default: return 8'($urandom);
        endcase
    endfunction

    // Random items are mostly laid out as scanlines of random length that open
    // with line_start; a few stray line_start flags fall mid-line as noise.
    function automatic void add_random_pairs(input int n);
        t_pair p;
        for (int i = 0; i < n; i++) begin
            p.cb = 8'($urandom);
            p.y0 = 8'($urandom);
            p.cr = 8'($urandom);
            p.y1 = 8'($urandom);
            p.key0 = $urandom;
            p.key1 = $urandom;
            p.key0[31:24] = random_alpha();
            // Neighboring key pixels often share alpha, as in real key fills.
            p.key1[31:24] = ($urandom_range(3) == 0) ? p.key0[31:24] : random_alpha();
            if (line_left == 0) begin
                line_left = $urandom_range(1, 20);
                p.line_start = 1'b1;
            end else begin
                p.line_start = ($urandom_range(19) == 0);
            end
            line_left--;
            pairs_pending.push_back(p);
            queued_n++;
        end
    endfunction

    // Waits until every queued item has been taken and every prediction met,
    // then lets the pipeline settle so that a register write finds it idle.
    task automatic wait_quiet();
        while (accepted_n != queued_n || blends_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rkob_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rkob_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == rkob_pkg::CFG_GLOBAL_ALPHA) begin
            opacity = data;
        end else if (idx == rkob_pkg::CFG_KEY_ORDER) begin
            key_order = data[0];
        end
    endtask

    task automatic set_mode(input logic [7:0] new_opacity, input logic new_order,
                            input int send_pct, input int recv_pct);
        write_reg(rkob_pkg::CFG_GLOBAL_ALPHA, new_opacity);
        write_reg(rkob_pkg::CFG_KEY_ORDER, rkob_pkg::CFG_DATA_W'(new_order));
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        settings_n++;
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset settings: full opacity, RGBA order.
        // The very first item has no line_start, so the chroma filter sees the
        // all-zero history left by reset.
        add_pair(8'h80, 8'h10, 8'h80, 8'heb, 32'hc0_20_40_ff, 32'h80_ff_80_00, 1'b0);
        add_pair(8'h00, 8'h00, 8'h00, 8'h00, 32'h00_00_00_00, 32'h00_00_00_00, 1'b1);
        add_pair(8'hff, 8'hff, 8'hff, 8'hff, 32'hff_ff_ff_ff, 32'hff_ff_ff_ff, 1'b0);
        // Fully opaque black over white: background weight goes to minus one.
        add_pair(8'hff, 8'hff, 8'hff, 8'hff, 32'hff_00_00_00, 32'hff_00_00_00, 1'b0);
        // Fully opaque white over black.
        add_pair(8'h00, 8'h00, 8'h00, 8'h00, 32'hff_ff_ff_ff, 32'hff_ff_ff_ff, 1'b1);
        // Transparent keys leave only the rounding of the scaled alpha.
        add_pair(8'h5a, 8'ha5, 8'h3c, 8'hc3, 32'h00_12_34_56, 32'h00_ab_cd_ef, 1'b0);
        // Pure primaries, one opaque and one transparent pixel per item.
        add_pair(8'h80, 8'h80, 8'h80, 8'h80, 32'hff_00_00_ff, 32'h00_00_ff_00, 1'b1);
        add_pair(8'h80, 8'h80, 8'h80, 8'h80, 32'h00_ff_00_00, 32'hff_00_00_ff, 1'b0);
        add_pair(8'h12, 8'h34, 8'h56, 8'h78, 32'h7f_ff_00_80, 32'h81_00_ff_7f, 1'b1);
        wait_quiet();

        // Zero opacity in BGRA order. Red and blue differ in most keys so a
        // wrong byte order shows; scaled alphas are all one, never zero.
        set_mode(8'd0, rkob_pkg::KEY_ORDER_BGRA, IDLE_NONE, IDLE_NONE);
        add_pair(8'h10, 8'heb, 8'hf0, 8'h10, 32'hff_10_80_f0, 32'hff_f0_80_10, 1'b1);
        add_pair(8'hff, 8'h00, 8'h00, 8'hff, 32'h00_ff_00_00, 32'h00_00_00_ff, 1'b0);
        add_pair(8'h00, 8'hff, 8'hff, 8'h00, 32'hff_ff_ff_ff, 32'h00_00_00_00, 1'b0);
        add_pair(8'h77, 8'h88, 8'h99, 8'haa, 32'h80_20_60_a0, 32'h80_a0_60_20, 1'b1);
        wait_quiet();

        // Smallest nonzero opacity, RGBA, one item.
        set_mode(8'd1, rkob_pkg::KEY_ORDER_RGBA, IDLE_NONE, IDLE_NONE);
        add_pair(8'h40, 8'hc0, 8'hc0, 8'h40, 32'hff_40_80_c0, 32'hff_c0_80_40, 1'b1);
        wait_quiet();

        // Random part: each setting pairs an opacity and key order with a back-pressure pattern.
        set_mode(8'd0, rkob_pkg::KEY_ORDER_BGRA, IDLE_HEAVY, IDLE_NONE);
        add_random_pairs(100);
        wait_quiet();

        set_mode(8'd255, rkob_pkg::KEY_ORDER_RGBA, IDLE_NONE, IDLE_NONE);
        add_random_pairs(120);
        wait_quiet();

        set_mode(8'($urandom_range(2, 254)), rkob_pkg::KEY_ORDER_BGRA, IDLE_NONE, IDLE_HEAVY);
        add_random_pairs(120);
        wait_quiet();

        set_mode(8'd1, rkob_pkg::KEY_ORDER_RGBA, IDLE_LIGHT, IDLE_LIGHT);
        add_random_pairs(100);
        wait_quiet();

        set_mode(8'd255, rkob_pkg::KEY_ORDER_BGRA, IDLE_NONE, IDLE_NONE);
        add_random_pairs(60);
        wait_quiet();

        $display("Run covered %0d items under %0d register settings (opacity 0, 1, 255 and",
                 accepted_n, settings_n);
        $display("a random mid value, both key orders) with %0d result items checked.",
                 checked_n);
        if (errors == 0 && blends_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // This timeout leaves a wide margin over a correct run.
    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
